[src/fhct_pkg.sv]
// ----------------------------------------------------------------------------
// fhct_pkg
// Shared widths, types and register codes for the frustum cull unit.
// ----------------------------------------------------------------------------
package fhct_pkg;

  localparam int COORD_W     = 16;   // coordinate width, two's complement
  localparam int COEF_W      = 16;   // a, b, c in Q1.14, d integer
  localparam int FRAC_BITS   = 14;
  localparam int PLANE_COUNT = 6;
  localparam int AXES        = 3;
  localparam int PROD_W      = COORD_W + COEF_W;
  localparam int SUM_W       = PROD_W + 2;   // three products plus scaled d

  localparam int APB_DATA_W  = 64;
  localparam int REG_SEL_LSB = 3;            // registers on 8-byte strides
  localparam int REG_SEL_W   = 3;
  localparam int APB_ADDR_W  = REG_SEL_LSB + REG_SEL_W;

  typedef logic signed [COORD_W-1:0]    coord_t;
  typedef logic signed [COEF_W-1:0]     coef_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic [PLANE_COUNT-1:0]       plane_mask_t;
  typedef logic [APB_DATA_W-1:0]        apb_data_t;
  typedef logic [APB_ADDR_W-1:0]        apb_addr_t;

  // Register layout: d at 63:48, c at 47:32, b at 31:16, a at 15:0.
  typedef struct packed {
    coef_t d;
    coef_t c;
    coef_t b;
    coef_t a;
  } plane_t;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_NEAR,
    REG_FAR,
    REG_LEFT,
    REG_RIGHT,
    REG_TOP,
    REG_BOTTOM
  } reg_idx_t;

  typedef enum logic {
    KIND_VERTEX,
    KIND_BOX
  } kind_t;

endpackage

[src/fhct_if.sv]
// ----------------------------------------------------------------------------
// fhct_if
// Request and result channels of the frustum cull unit (valid/ready).
// ----------------------------------------------------------------------------
interface fhct_req_if;
  import fhct_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  coord_t min_x;
  coord_t min_y;
  coord_t min_z;
  coord_t max_x;
  coord_t max_y;
  coord_t max_z;
  logic   last;

  modport source (
    output valid, kind, min_x, min_y, min_z, max_x, max_y, max_z, last,
    input  ready
  );
  modport sink (
    input  valid, kind, min_x, min_y, min_z, max_x, max_y, max_z, last,
    output ready
  );
endinterface

interface fhct_res_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

[src/frustum_hull_cull_test_unit.sv]
// ----------------------------------------------------------------------------
// frustum_hull_cull_test_unit
// Six-plane view-frustum cull of points, convex hulls and boxes.
// Path: a query's closing request (box, or vertex with last set) passes the
//   request and product registers; its result is then registered into res.
// Throughput: one request per cycle while res takes results; the request,
//   product and result registers each hold one request.
// Reset: synchronous, active high; clears all planes to zero, the per-query
//   plane state and all valid flags.
// ----------------------------------------------------------------------------
module frustum_hull_cull_test_unit (
  input  logic                  clk,
  input  logic                  rst,
  fhct_req_if.sink              req,
  fhct_res_if.source            res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  fhct_pkg::apb_addr_t   paddr,
  input  fhct_pkg::apb_data_t   pwdata,
  output fhct_pkg::apb_data_t   prdata,
  output logic                  pready
);
  import fhct_pkg::*;

  // --------------------------------------------------------------------------
  // Plane registers (APB). Writes past the last plane are dropped.
  // --------------------------------------------------------------------------
  plane_t                 plane [PLANE_COUNT];
  logic [REG_SEL_W-1:0]   reg_sel;
  logic                   reg_hit;
  logic                   reg_wr;

  assign reg_sel = paddr[APB_ADDR_W-1:REG_SEL_LSB];
  assign reg_hit = (reg_sel <= REG_BOTTOM);
  assign reg_wr  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? apb_data_t'(plane[reg_sel]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        plane[p] <= '0;
      end
    end else if (reg_wr) begin
      plane[reg_sel] <= plane_t'(pwdata);
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Each stage refills when it empties or moves on.
  // A request that closes a query needs room in the result register;
  // open hull vertices drain regardless of the result side.
  // --------------------------------------------------------------------------
  logic   s1_valid;
  logic   s1_kind;
  logic   s1_last;
  coord_t s1_lo [AXES];
  coord_t s1_hi [AXES];

  logic   s2_valid;
  logic   s2_kind;
  logic   s2_last;
  prod_t  s2_prod [PLANE_COUNT][AXES];

  logic   out_free;
  logic   s2_emits;
  logic   s2_fire;
  logic   s2_open;
  logic   s1_open;

  assign out_free  = !res.valid || res.ready;
  assign s2_emits  = (s2_kind == KIND_BOX) || s2_last;
  assign s2_fire   = s2_valid && (!s2_emits || out_free);
  assign s2_open   = !s2_valid || s2_fire;
  assign s1_open   = !s1_valid || s2_open;
  assign req.ready = s1_open;

  // --------------------------------------------------------------------------
  // Stage 1 -> 2: corner pick and products.
  // For a box the corner with the largest plane distance decides: per axis
  // take the larger coordinate where the coefficient is non-negative, else
  // the smaller one. Min above max is fine, nothing gets swapped.
  // --------------------------------------------------------------------------
  coef_t  coef      [PLANE_COUNT][AXES];
  coord_t pick      [PLANE_COUNT][AXES];
  prod_t  prod_next [PLANE_COUNT][AXES];

  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      coef[p][0] = plane[p].a;
      coef[p][1] = plane[p].b;
      coef[p][2] = plane[p].c;
    end
  end

  always_comb begin
    logic hi_ge;
    logic take_hi;
    hi_ge   = 1'b0;
    take_hi = 1'b0;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int ax = 0; ax < AXES; ax++) begin
        hi_ge   = (s1_hi[ax] >= s1_lo[ax]);
        take_hi = coef[p][ax][COEF_W-1] ? !hi_ge : hi_ge;
        if ((s1_kind == KIND_BOX) && take_hi) begin
          pick[p][ax] = s1_hi[ax];
        end else begin
          pick[p][ax] = s1_lo[ax];
        end
        prod_next[p][ax] = prod_t'(coef[p][ax]) * prod_t'(pick[p][ax]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sum, sign test, per-query accumulate.
  // --------------------------------------------------------------------------
  plane_mask_t reached;
  plane_mask_t lane_mask;
  plane_mask_t mask_all;
  sum_t        plane_dist [PLANE_COUNT];

  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      plane_dist[p] = SUM_W'(s2_prod[p][0]) + SUM_W'(s2_prod[p][1])
                    + SUM_W'(s2_prod[p][2]) + (SUM_W'(plane[p].d) <<< FRAC_BITS);
      lane_mask[p] = !plane_dist[p][SUM_W-1];
    end
  end

  assign mask_all = reached | lane_mask;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      reached   <= '0;
      res.valid <= 1'b0;
    end else begin
      if (s1_open) begin
        s1_valid <= req.valid;
      end
      if (s2_open) begin
        s2_valid <= s1_valid;
      end
      if (s2_fire) begin
        reached <= s2_emits ? '0 : mask_all;
      end
      if (s2_fire && s2_emits) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_open && req.valid) begin
      s1_kind  <= req.kind;
      s1_last  <= req.last;
      s1_lo[0] <= req.min_x;
      s1_lo[1] <= req.min_y;
      s1_lo[2] <= req.min_z;
      s1_hi[0] <= req.max_x;
      s1_hi[1] <= req.max_y;
      s1_hi[2] <= req.max_z;
    end
    if (s2_open && s1_valid) begin
      s2_kind <= s1_kind;
      s2_last <= s1_last;
      s2_prod <= prod_next;
    end
    if (s2_fire && s2_emits) begin
      res.inside_res <= &mask_all;
    end
  end

endmodule

[src/fhct_checker.sv]
// ----------------------------------------------------------------------------
// fhct_checker
// Port-level checks for the frustum cull unit, bound to the top level.
// ----------------------------------------------------------------------------
module fhct_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_inside,
  input logic pready
);

  // Pipeline is empty after reset: no result, room for a request.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!res_valid && req_ready))
    else $error("unit not empty after reset");

  // A stalled result keeps its value.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_inside)))
    else $error("stalled result changed");

  // Register port never inserts wait states.
  a_no_wait: assert property (@(posedge clk) pready)
    else $error("pready low");

  // With nothing pending the unit takes a request at once.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (!res_valid && !$past(req_valid) && !$past(req_valid, 2)) |-> req_ready)
    else $error("idle unit not ready");

endmodule

bind frustum_hull_cull_test_unit fhct_checker u_fhct_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_inside (res.inside_res),
  .pready     (pready)
);

[bench/frustum_cull_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frustum_cull_checker
// Snoops the plane register writes and both channels of the frustum cull
// unit, predicts the inside flag of every closed query and compares it with
// the results that leave the block, oldest first.
// ----------------------------------------------------------------------------
module frustum_cull_checker
  import fhct_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  fhct_req_if       req,
  fhct_res_if       res,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic      pready,
  input  apb_addr_t paddr,
  input  apb_data_t pwdata,
  output int        fail_count,
  output int        pending
);

  plane_t      planes [PLANE_COUNT];
  plane_mask_t reached;
  bit          inside_expected [$];
  int          errors = 0;

  // Planes that one point lies on or in front of; exact at 14 fraction bits.
  function automatic plane_mask_t planes_reached_by(coord_t x, coord_t y, coord_t z);
    plane_mask_t hit;
    plane_t      p;
    sum_t        s;
    hit = '0;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      p = planes[i];
      s = sum_t'(p.a) * sum_t'(x) + sum_t'(p.b) * sum_t'(y) + sum_t'(p.c) * sum_t'(z)
          + (sum_t'(p.d) <<< FRAC_BITS);
      hit[i] = !s[SUM_W-1];
    end
    return hit;
  endfunction

  always @(posedge clk) begin : watch
    int unsigned sel;
    bit          want;
    coord_t      cx;
    coord_t      cy;
    coord_t      cz;
    if (rst) begin
      for (int i = 0; i < PLANE_COUNT; i++) planes[i] = '0;
      reached = '0;
      inside_expected.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        sel = paddr[REG_SEL_LSB +: REG_SEL_W];
        if (sel < PLANE_COUNT) planes[sel] = plane_t'(pwdata);
      end
      if (req.valid && req.ready) begin
        if (req.kind == KIND_BOX) begin
          // all eight corners, min/max taken as given (no swap)
          for (int k = 0; k < 8; k++) begin
            cx = k[0] ? req.max_x : req.min_x;
            cy = k[2] ? req.max_y : req.min_y;
            cz = k[1] ? req.max_z : req.min_z;
            reached |= planes_reached_by(cx, cy, cz);
          end
        end else begin
          reached |= planes_reached_by(req.min_x, req.min_y, req.min_z);
        end
        if (req.kind == KIND_BOX || req.last) begin
          inside_expected.push_back(&reached);
          reached = '0;
        end
      end
      if (res.valid && res.ready) begin
        if (inside_expected.size() == 0) begin
          errors++;
          $display("%0t: inside_res expected none, actual %0b", $time, res.inside_res);
        end else begin
          want = inside_expected.pop_front();
          if (res.inside_res !== want) begin
            errors++;
            $display("%0t: inside_res expected %0b, actual %0b", $time, want, res.inside_res);
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= inside_expected.size();
  end

endmodule

[bench/frustum_hull_cull_test_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frustum_hull_cull_test_unit_test
// Drives points, hulls and boxes into the frustum cull unit under several
// plane sets loaded over APB, with random stalls on both channels, and lets
// the checker compare every inside flag against its own prediction.
// ----------------------------------------------------------------------------
module frustum_hull_cull_test_unit_test;
  import fhct_pkg::*;

  localparam coef_t ONE_Q14 = coef_t'(1 << FRAC_BITS);   // 1.0 in Q1.14

  typedef enum {
    STYLE_AXIS,      // cube of half size h around the origin
    STYLE_TILTED,    // random unit-ish normals, origin inside
    STYLE_RAW,       // any 64-bit pattern
    STYLE_EXTREME    // per plane: all max, all min, all ones or zero
  } plane_style_t;

  logic      clk;
  logic      rst;
  logic      psel;
  logic      penable;
  logic      pwrite;
  apb_addr_t paddr;
  apb_data_t pwdata;
  apb_data_t prdata;
  logic      pready;

  int fail_count;
  int pending;
  bit quiet;        // no idling on either side while set
  int coord_span;   // random coordinates mostly fall in +/- this

  fhct_req_if req_ch ();
  fhct_res_if res_ch ();

  frustum_hull_cull_test_unit uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frustum_cull_checker cull_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side backpressure: ready goes low now and then, otherwise stays
  // high for a random stretch; held high while quiet. A low burst always
  // ends with ready set high, never straight in another low burst.
  initial begin : res_ready_gen
    int hold;
    hold = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (quiet) begin
        res_ch.ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (res_ch.ready && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        res_ch.ready <= 1'b1;
        hold = $urandom_range(0, 7);
      end
    end
  end

  // Mostly near the frustum, sometimes anywhere in the 16-bit range.
  function automatic int pick_coord();
    if ($urandom_range(0, 7) == 0) return int'($urandom);
    return int'($urandom_range(0, 2 * coord_span)) - coord_span;
  endfunction

  // One request; optional idle burst first, then hold until ready.
  task automatic push_req(kind_t k, int x0, int y0, int z0, int x1, int y1, int z1,
                          bit lst);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= k;
    req_ch.min_x <= coord_t'(x0);
    req_ch.min_y <= coord_t'(y0);
    req_ch.min_z <= coord_t'(z0);
    req_ch.max_x <= coord_t'(x1);
    req_ch.max_y <= coord_t'(y1);
    req_ch.max_z <= coord_t'(z1);
    req_ch.last  <= lst;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Vertex: the max fields are don't-care, so fill them with noise.
  task automatic send_vertex(int x, int y, int z, bit lst);
    push_req(KIND_VERTEX, x, y, z, int'($urandom), int'($urandom), int'($urandom), lst);
  endtask

  task automatic send_box(int x0, int y0, int z0, int x1, int y1, int z1, bit lst);
    push_req(KIND_BOX, x0, y0, z0, x1, y1, z1, lst);
  endtask

  // APB write: setup then access; psel/penable left for the caller to drop
  // so that back-to-back writes never toggle psel within one step.
  task automatic apb_write(int unsigned idx, apb_data_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= apb_addr_t'(idx << REG_SEL_LSB);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Load all six planes in one style, then poke an unused slot (must be
  // dropped by the block).
  task automatic program_planes(plane_style_t style, int half);
    plane_t p;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      p = '0;
      case (style)
        STYLE_AXIS: begin
          p.d = coef_t'(half);
          case (reg_idx_t'(i))
            REG_NEAR:  p.c = ONE_Q14;     // z >= -h
            REG_FAR:   p.c = -ONE_Q14;    // z <= h
            REG_LEFT:  p.a = ONE_Q14;     // x >= -h
            REG_RIGHT: p.a = -ONE_Q14;    // x <= h
            REG_TOP:   p.b = -ONE_Q14;    // y <= h
            default:   p.b = ONE_Q14;     // y >= -h
          endcase
        end
        STYLE_TILTED: begin
          p.a = coef_t'(int'($urandom_range(0, 32768)) - 16384);
          p.b = coef_t'(int'($urandom_range(0, 32768)) - 16384);
          p.c = coef_t'(int'($urandom_range(0, 32768)) - 16384);
          p.d = coef_t'($urandom_range(0, half));
        end
        STYLE_RAW: p = {$urandom, $urandom};
        default: begin
          case ($urandom_range(0, 3))
            0:       p = {4{16'h7FFF}};
            1:       p = {4{16'h8000}};
            2:       p = '1;
            default: p = '0;
          endcase
        end
      endcase
      apb_write(i, p);
    end
    apb_write($urandom_range(PLANE_COUNT, (1 << REG_SEL_W) - 1), {$urandom, $urandom});
    psel    <= 1'b0;
    penable <= 1'b0;
    if (style == STYLE_AXIS || style == STYLE_TILTED)
      coord_span = (2 * half > 32767) ? 32767 : 2 * half;
    else
      coord_span = 32767;
  endtask

  // Drain: every query closed, wait for its result, then let the pipe empty.
  // The first edge lets the checker's count catch the last closing request.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random traffic: mostly whole hulls of 1..6 vertices and boxes, with some
  // hulls cut short by an early last or by a box. Always ends closed.
  task automatic run_phase(int count);
    int n;
    int left;
    int sel;
    n    = 0;
    left = 0;
    while (n < count || left != 0) begin
      sel = $urandom_range(0, 99);
      if (left == 0 && sel < 30) begin
        send_box(pick_coord(), pick_coord(), pick_coord(),
                 pick_coord(), pick_coord(), pick_coord(), $urandom_range(0, 1));
      end else begin
        if (left == 0)
          left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(1, 3);
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
          // box may land mid-hull; it closes the query
          send_box(pick_coord(), pick_coord(), pick_coord(),
                   pick_coord(), pick_coord(), pick_coord(), $urandom_range(0, 1));
          left = 0;
        end else if (sel < 10) begin
          send_vertex(pick_coord(), pick_coord(), pick_coord(), 1'b1);
          left = 0;
        end else begin
          send_vertex(pick_coord(), pick_coord(), pick_coord(), left == 1);
          left--;
        end
      end
      n++;
    end
  endtask

  initial begin : stimulus
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.kind  <= KIND_VERTEX;
    req_ch.min_x <= '0;
    req_ch.min_y <= '0;
    req_ch.min_z <= '0;
    req_ch.max_x <= '0;
    req_ch.max_y <= '0;
    req_ch.max_z <= '0;
    req_ch.last  <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    quiet        = 1'b0;
    coord_span   = 32767;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Planes still at reset (all zero): every point sits on every plane.
    run_phase(20);
    settle();

    // Directed checks against a +/-1000 cube.
    program_planes(STYLE_AXIS, 1000);
    send_vertex(0, 0, 0, 1'b1);                         // origin: in
    send_vertex(1000, 1000, 1000, 1'b1);                // on the faces: in
    send_vertex(1001, 0, 0, 1'b1);                      // just past right: out
    send_vertex(-32768, -32768, -32768, 1'b1);          // most negative: out
    send_vertex(32767, 32767, 32767, 1'b1);             // most positive: out
    send_vertex(2000, 0, 0, 1'b0);                      // straddles x: in
    send_vertex(-2000, 0, 0, 1'b1);
    send_vertex(2000, 0, 0, 1'b0);                      // all beyond right: out
    send_vertex(3000, 5, 5, 1'b0);
    send_vertex(1500, -5, 0, 1'b1);
    send_box(-500, -500, -500, 500, 500, 500, 1'b1);    // box inside
    send_box(2000, 2000, 2000, 3000, 3000, 3000, 1'b0); // box outside
    send_box(500, 500, 500, -500, -500, -500, 1'b1);    // min above max
    send_box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b0);  // encloses
    send_box(32767, 32767, 32767, -32768, -32768, -32768, 1'b1);  // swapped extremes
    // open hull closed by a box: each alone is out, together in
    send_vertex(2000, 0, 0, 1'b0);
    send_box(-3000, -10, -10, -2000, 10, 10, 1'b0);
    send_vertex(5000, 5000, 5000, 1'b1);                // out, then state clears
    send_vertex(0, 0, 0, 1'b1);
    run_phase(80);
    settle();

    program_planes(STYLE_AXIS, $urandom_range(1, 16000));
    run_phase(100);
    settle();

    // a stretch with no idling at all
    quiet = 1'b1;
    program_planes(STYLE_TILTED, $urandom_range(500, 20000));
    run_phase(100);
    settle();
    quiet = 1'b0;

    program_planes(STYLE_RAW, 0);
    run_phase(100);
    settle();

    program_planes(STYLE_EXTREME, 0);
    run_phase(60);
    settle();

    // largest d the register holds
    program_planes(STYLE_AXIS, 32767);
    run_phase(60);
    settle();

    program_planes(STYLE_EXTREME, 0);
    run_phase(60);
    settle();

    program_planes(STYLE_TILTED, $urandom_range(500, 32767));
    run_phase(100);
    settle();

    // closing part runs at full rate
    quiet = 1'b1;
    program_planes(STYLE_AXIS, $urandom_range(1, 16000));
    run_phase(100);
    settle();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/fhct_pkg.sv
src/fhct_if.sv
src/frustum_hull_cull_test_unit.sv
src/fhct_checker.sv
bench/frustum_cull_checker.sv
bench/frustum_hull_cull_test_unit_test.sv
